>>> hdl/sis_pkg.sv
`default_nettype none

package sis_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned CAPACITY_DEF = 1024;

  // Control bits that ride along with one request as it walks the chain.
  typedef struct packed {
    logic vld;     // a request occupies this slot
    logic placed;  // the new key has been dropped into a cell already
    logic full;    // store was full on entry: no insert, pass straight through
  } ctl_t;

endpackage

`default_nettype wire

>>> hdl/sis_entry.sv
`default_nettype none

module sis_entry #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned CW       = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic signed [sis_pkg::KEY_W-1:0] key,
  output sis_pkg::ctl_t                      tok_ctl,
  output logic signed [sis_pkg::KEY_W-1:0]   tok_key,
  output logic [sis_pkg::POS_W-1:0]          tok_pos,
  output logic [CW-1:0]                      tok_n
);
  import sis_pkg::*;

  logic [CW-1:0]           count_r, count_nxt;
  ctl_t                    ctl_r, ctl_nxt;
  logic signed [KEY_W-1:0] key_r;
  logic [POS_W-1:0]        pos_r;
  logic [CW-1:0]           n_r;
  logic                    is_full;

  assign is_full = (count_r == CW'(CAPACITY));

  always_comb begin
    count_nxt = count_r;
    if (accept && !is_full) begin
      count_nxt = count_r + CW'(1);
    end
    ctl_nxt.vld    = accept;
    ctl_nxt.placed = 1'b0;
    ctl_nxt.full   = is_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ctl_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  // Payload: count before this insert is the landing cell for the last carried key.
  always_ff @(posedge clk) begin
    key_r <= key;
    pos_r <= '0;
    n_r   <= count_r;
  end

  assign tok_ctl = ctl_r;
  assign tok_key = key_r;
  assign tok_pos = pos_r;
  assign tok_n   = n_r;

endmodule

`default_nettype wire

>>> hdl/sis_cell.sv
`default_nettype none

module sis_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 11
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire sis_pkg::ctl_t                    in_ctl,
  input  wire logic signed [sis_pkg::KEY_W-1:0] in_key,
  input  wire logic [sis_pkg::POS_W-1:0]        in_pos,
  input  wire logic [CW-1:0]                    in_n,
  output sis_pkg::ctl_t                         out_ctl,
  output logic signed [sis_pkg::KEY_W-1:0]      out_key,
  output logic [sis_pkg::POS_W-1:0]             out_pos,
  output logic [CW-1:0]                         out_n
);
  import sis_pkg::*;

  logic signed [KEY_W-1:0] key_r, key_nxt;
  ctl_t                    ctl_r, ctl_nxt;
  logic signed [KEY_W-1:0] fwd_r, fwd_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]           n_r;
  logic                    active;
  logic                    at_end;
  logic                    swap;

  // Cells below the pre-insert count hold keys; the cell at the count is the free slot.
  assign active = in_ctl.vld && !in_ctl.full && (CW'(IDX) <= in_n);
  assign at_end = (CW'(IDX) == in_n);
  assign swap   = active && (at_end || in_ctl.placed || (in_key <= key_r));

  always_comb begin
    key_nxt = key_r;
    ctl_nxt = in_ctl;
    fwd_nxt = in_key;
    pos_nxt = in_pos;
    if (swap) begin
      // take the carried key, hand the displaced one up the chain
      key_nxt = in_key;
      fwd_nxt = key_r;
      if (!in_ctl.placed) begin
        ctl_nxt.placed = 1'b1;
        pos_nxt        = POS_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    fwd_r <= fwd_nxt;
    pos_r <= pos_nxt;
    n_r   <= in_n;
  end

  assign out_ctl = ctl_r;
  assign out_key = fwd_r;
  assign out_pos = pos_r;
  assign out_n   = n_r;

endmodule

`default_nettype wire

>>> hdl/sorted_insert_store.sv
// Channel  | Handshake        | Payload
// request  | start / busy     | in_key (signed 32)
// result   | out_valid strobe | out_position, out_entry_count, out_full_res
//
// One request is taken every cycle; busy stays low.
// Each request walks a chain of CAPACITY cells, one cell per cycle, so its
// result strobes out of the last cell, in request order.
// rst_n is synchronous; it empties the store (count back to zero).
// The result side cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module sorted_insert_store #(
  parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [sis_pkg::KEY_W-1:0] in_key,
  output logic                                  out_valid,
  output logic [sis_pkg::POS_W-1:0]             out_position,
  output logic [sis_pkg::CNT_W-1:0]             out_entry_count,
  output logic                                  out_full_res
);
  import sis_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ctl_t                    ctl_chain [CAPACITY+1];
  logic signed [KEY_W-1:0] key_chain [CAPACITY+1];
  logic [POS_W-1:0]        pos_chain [CAPACITY+1];
  logic [CW-1:0]           n_chain   [CAPACITY+1];
  logic                    accept;
  logic [CW-1:0]           cnt_after;
  ctl_t                    tail;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  sis_entry #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_entry (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .key     (in_key),
    .tok_ctl (ctl_chain[0]),
    .tok_key (key_chain[0]),
    .tok_pos (pos_chain[0]),
    .tok_n   (n_chain[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sis_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (ctl_chain[i]),
      .in_key  (key_chain[i]),
      .in_pos  (pos_chain[i]),
      .in_n    (n_chain[i]),
      .out_ctl (ctl_chain[i+1]),
      .out_key (key_chain[i+1]),
      .out_pos (pos_chain[i+1]),
      .out_n   (n_chain[i+1])
    );
  end

  assign tail      = ctl_chain[CAPACITY];
  assign cnt_after = n_chain[CAPACITY] + CW'(!tail.full);

  assign out_valid       = tail.vld;
  assign out_position    = pos_chain[CAPACITY];
  assign out_entry_count = CNT_W'(cnt_after);
  assign out_full_res    = tail.vld && tail.full;

  // key_chain tail is unused: the last displaced key lands in the free cell.
  logic unused_tail_key;
  assign unused_tail_key = ^key_chain[CAPACITY];

endmodule

`default_nettype wire

>>> hdl/sis_checker.sv
`default_nettype none

module sis_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic signed [sis_pkg::KEY_W-1:0] in_key,
  input wire logic                             out_valid,
  input wire logic [sis_pkg::POS_W-1:0]        out_position,
  input wire logic [sis_pkg::CNT_W-1:0]        out_entry_count,
  input wire logic                             out_full_res
);
  import sis_pkg::*;

  logic unused_in;
  assign unused_in = start ^ busy ^ (^in_key);

  a_full_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_res |-> out_valid)
    else $error("full flag without result strobe");

  a_drop_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_res) |-> (out_position == '0))
    else $error("dropped request reports nonzero position");

  a_pos_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_full_res && (out_entry_count != '0))
      |-> ({1'b0, out_position} < out_entry_count))
    else $error("insert position not below entry count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && $past(rst_n))
      |-> ((out_entry_count == $past(out_entry_count) + CNT_W'(1)) ||
           (out_full_res && (out_entry_count == $past(out_entry_count)))))
    else $error("entry count did not advance by one between results");

endmodule

bind sorted_insert_store sis_checker u_sis_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_key          (in_key),
  .out_valid       (out_valid),
  .out_position    (out_position),
  .out_entry_count (out_entry_count),
  .out_full_res    (out_full_res)
);

`default_nettype wire
